// ===== hdl/softened_gravity_pair_accel_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the softened gravity pair accelerator
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef SOFTENED_GRAVITY_PAIR_ACCEL_ASSERT_SVH
`define SOFTENED_GRAVITY_PAIR_ACCEL_ASSERT_SVH

// same-cycle implication
`define SGPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sgpa_pkg.sv =====
// ---------------------------------------------------------------------------
// sgpa_pkg
// Widths, codes and shared types of the softened gravity pair accelerator.
// ---------------------------------------------------------------------------
`default_nettype none

package sgpa_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int MAG_W          = 32;   // |b - a| of two 32-bit codes
    localparam int SQ_W           = 64;
    localparam int GM_W           = 64;   // G * mass
    localparam int R2_W           = 66;
    localparam int FRAC_PAD       = 32;
    localparam int RAD_W          = R2_W + FRAC_PAD;
    localparam int ROOT_W         = RAD_W / 2;
    localparam int P_W            = R2_W + ROOT_W;
    localparam int NUM_SHIFT      = 24;
    localparam int NUM_W          = GM_W + MAG_W + NUM_SHIFT;
    localparam int QUOT_W         = 32;
    localparam int DIV_LANES      = 6;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [0:0] REG_GRAVITY = 1'b0;
    localparam logic [0:0] REG_SOFTEN  = 1'b1;

    localparam logic [DATA_W-1:0] GRAVITY_RESET = 32'd16777216;
    localparam logic [DATA_W-1:0] SOFTEN_RESET  = 32'd655;

    localparam logic [QUOT_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [QUOT_W-1:0] LIMIT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] gravity_const;
        logic [DATA_W-1:0] softening;
    } cfg_t;

    typedef struct packed {
        logic [GM_W-1:0]            ga;
        logic [GM_W-1:0]            gb;
        logic [2:0][MAG_W-1:0]      mag;
        logic [2:0]                 neg;
        logic                       zero;
        logic [R2_W-1:0]            r2;
    } sq_side_t;

    typedef struct packed {
        logic [2:0] neg_a;
        logic [2:0] neg_b;
        logic       zero;
    } dv_side_t;

    localparam int SQ_SIDE_W = $bits(sq_side_t);
    localparam int DV_SIDE_W = $bits(dv_side_t);

endpackage

`default_nettype wire

// ===== hdl/sgpa_regs.sv =====
// ---------------------------------------------------------------------------
// sgpa_regs
// APB register file: gravitational constant and softening length.
// ---------------------------------------------------------------------------
`default_nettype none

module sgpa_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sgpa_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sgpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sgpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output sgpa_pkg::cfg_t                       cfg
);
    import sgpa_pkg::*;

    logic [DATA_W-1:0] gravity_reg;
    logic [DATA_W-1:0] soften_reg;
    logic              wr_en;
    logic [0:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= GRAVITY_RESET;
            soften_reg  <= SOFTEN_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GRAVITY: gravity_reg <= pwdata;
                REG_SOFTEN:  soften_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRAVITY: prdata = gravity_reg;
            REG_SOFTEN:  prdata = soften_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.gravity_const = gravity_reg;
    assign cfg.softening     = soften_reg;

endmodule

`default_nettype wire

// ===== hdl/sgpa_sqrt.sv =====
// ---------------------------------------------------------------------------
// sgpa_sqrt
// Pipelined restoring square root, one root bit per stage, side data along.
// ---------------------------------------------------------------------------
`default_nettype none

module sgpa_sqrt #(
    parameter int RAD_W  = sgpa_pkg::RAD_W,
    parameter int SIDE_W = sgpa_pkg::SQ_SIDE_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire logic [RAD_W-1:0]      in_rad,
    input  wire logic [SIDE_W-1:0]     in_side,
    output logic                       out_valid,
    output logic      [RAD_W/2-1:0]    out_root,
    output logic      [SIDE_W-1:0]     out_side
);
    localparam int RT_W  = RAD_W / 2;
    localparam int REM_W = RT_W + 3;

    logic [RT_W:0]      valid_reg;
    logic [RAD_W-1:0]   rad_reg  [0:RT_W];
    logic [RT_W-1:0]    root_reg [0:RT_W];
    logic [REM_W-1:0]   rem_reg  [0:RT_W];
    logic [SIDE_W-1:0]  side_reg [0:RT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg[0]  <= in_rad;
            root_reg[0] <= '0;
            rem_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < RT_W; j++) begin : g_step
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;
        logic [REM_W-1:0] rem_next;
        logic [RT_W-1:0]  root_next;

        always_comb begin
            // bring down the next two radicand bits
            rem_sh    = {rem_reg[j][REM_W-3:0], rad_reg[j][RAD_W-1-2*j -: 2]};
            trial     = REM_W'({root_reg[j], 2'b01});
            ge        = rem_sh >= trial;
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[j][RT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[j+1]  <= rad_reg[j];
                root_reg[j+1] <= root_next;
                rem_reg[j+1]  <= rem_next;
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[RT_W];
    assign out_root  = root_reg[RT_W];
    assign out_side  = side_reg[RT_W];

endmodule

`default_nettype wire

// ===== hdl/sgpa_div.sv =====
// ---------------------------------------------------------------------------
// sgpa_div
// Pipelined restoring divider, several lanes sharing one divisor.
// First stage flags quotients of 2^Q_W or more, then one bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module sgpa_div #(
    parameter int LANES  = sgpa_pkg::DIV_LANES,
    parameter int N_W    = sgpa_pkg::NUM_W,
    parameter int D_W    = sgpa_pkg::P_W,
    parameter int Q_W    = sgpa_pkg::QUOT_W,
    parameter int SIDE_W = sgpa_pkg::DV_SIDE_W
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][N_W-1:0]     in_num,
    input  wire logic [D_W-1:0]                in_den,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic      [LANES-1:0][Q_W-1:0]     out_quot,
    output logic      [LANES-1:0]              out_over,
    output logic      [SIDE_W-1:0]             out_side
);
    localparam int CW = D_W + Q_W + 1;

    logic [Q_W:0]                 valid_reg;
    logic [LANES-1:0][N_W-1:0]    rem_reg  [0:Q_W];
    logic [LANES-1:0][Q_W-1:0]    quot_reg [0:Q_W];
    logic [LANES-1:0]             over_reg [0:Q_W];
    logic [D_W-1:0]               den_reg  [0:Q_W];
    logic [SIDE_W-1:0]            side_reg [0:Q_W];
    logic [LANES-1:0]             over_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            over_next[l] = CW'(in_num[l]) >= {1'b0, in_den, {Q_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= in_num;
            quot_reg[0] <= '0;
            over_reg[0] <= over_next;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int B = Q_W - 1 - j;
        logic [CW-1:0]              trial;
        logic [LANES-1:0][N_W-1:0]  rem_next;
        logic [LANES-1:0][Q_W-1:0]  quot_next;

        always_comb begin
            trial = CW'(den_reg[j]) << B;
            for (int l = 0; l < LANES; l++) begin
                if (CW'(rem_reg[j][l]) >= trial) begin
                    rem_next[l]  = N_W'(CW'(rem_reg[j][l]) - trial);
                    quot_next[l] = quot_reg[j][l] | (Q_W'(1) << B);
                end else begin
                    rem_next[l]  = rem_reg[j][l];
                    quot_next[l] = quot_reg[j][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j+1]  <= rem_next;
                quot_reg[j+1] <= quot_next;
                over_reg[j+1] <= over_reg[j];
                den_reg[j+1]  <= den_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign out_quot  = quot_reg[Q_W];
    assign out_over  = over_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

`default_nettype wire

// ===== hdl/softened_gravity_pair_accel.sv =====
// Stages 1 to 3, the 50-stage square root, multiply stages 1 and 2, the
// 33-stage divider and the output register run in order. Throughput: one
// pair per cycle; the whole pipeline holds while a result awaits m_ready.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads
// gravity_const = 1.0 (Q8.24) and softening = 655 (Q16.16).
// ---------------------------------------------------------------------------
// softened_gravity_pair_accel
// Plummer-softened pairwise gravity: G*m*d/r^3 for both particles of a pair.
// ---------------------------------------------------------------------------
`default_nettype none

`include "softened_gravity_pair_accel_assert.svh"

module softened_gravity_pair_accel #(
    parameter int COORD_BITS = sgpa_pkg::COORD_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sgpa_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sgpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sgpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_first_x,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_first_y,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_first_z,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_second_x,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_second_y,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_second_z,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_first_mass,
    input  wire logic [sgpa_pkg::DATA_W-1:0]     s_second_mass,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [sgpa_pkg::DATA_W-1:0]     m_accel_first_x,
    output logic      [sgpa_pkg::DATA_W-1:0]     m_accel_first_y,
    output logic      [sgpa_pkg::DATA_W-1:0]     m_accel_first_z,
    output logic      [sgpa_pkg::DATA_W-1:0]     m_accel_second_x,
    output logic      [sgpa_pkg::DATA_W-1:0]     m_accel_second_y,
    output logic      [sgpa_pkg::DATA_W-1:0]     m_accel_second_z,
    output logic      [1:0]                      m_status
);
    import sgpa_pkg::*;

    localparam int POS_W = (COORD_BITS < DATA_W) ? COORD_BITS : DATA_W;
    localparam int EXT_W = DATA_W + 1 - POS_W;

    function automatic logic [QUOT_W:0] encode(input logic [QUOT_W-1:0] q,
                                               input logic over,
                                               input logic neg);
        logic [QUOT_W-1:0] lim;
        logic              sat;
        logic [QUOT_W-1:0] m;
        logic [QUOT_W-1:0] code;
        lim  = neg ? LIMIT_NEG : LIMIT_POS;
        sat  = over || (q > lim);
        m    = sat ? lim : q;
        code = neg ? (-m) : m;
        return {sat, code};
    endfunction

    cfg_t cfg;
    logic adv;

    // input side
    logic [2:0][DATA_W-1:0] pos_a;
    logic [2:0][DATA_W-1:0] pos_b;
    logic [2:0][MAG_W-1:0]  mag_next;
    logic [2:0]             neg_next;

    // stage 1
    logic                   v1_reg;
    logic [2:0][MAG_W-1:0]  mag1_reg;
    logic [2:0]             neg1_reg;
    logic [DATA_W-1:0]      ma1_reg;
    logic [DATA_W-1:0]      mb1_reg;

    // stage 2
    logic                   v2_reg;
    logic [2:0][SQ_W-1:0]   sq2_reg;
    logic [SQ_W-1:0]        ssq2_reg;
    logic [GM_W-1:0]        ga2_reg;
    logic [GM_W-1:0]        gb2_reg;
    logic [2:0][MAG_W-1:0]  mag2_reg;
    logic [2:0]             neg2_reg;
    logic                   zero2_reg;

    // stage 3
    logic                   v3_reg;
    logic [R2_W-1:0]        r2_reg;
    logic [GM_W-1:0]        ga3_reg;
    logic [GM_W-1:0]        gb3_reg;
    logic [2:0][MAG_W-1:0]  mag3_reg;
    logic [2:0]             neg3_reg;
    logic                   zero3_reg;
    sq_side_t               sq_in_side;

    // square root output
    logic                   sq_valid;
    logic [ROOT_W-1:0]      sq_root;
    logic [SQ_SIDE_W-1:0]   sq_side_raw;
    sq_side_t               sq_side;

    // multiply stage 1
    logic                   vm1_reg;
    logic [57:0]            pll_reg;
    logic [56:0]            plh_reg;
    logic [57:0]            phl_reg;
    logic [56:0]            phh_reg;
    logic [5:0][SQ_W-1:0]   nlo_reg;
    logic [5:0][SQ_W-1:0]   nhi_reg;
    dv_side_t               dm1_reg;
    logic [5:0][MAG_W-1:0]  lane_mag;
    logic [5:0][DATA_W-1:0] lane_glo;
    logic [5:0][DATA_W-1:0] lane_ghi;
    dv_side_t               dm1_next;

    // multiply stage 2
    logic                   vm2_reg;
    logic [P_W-1:0]         p_reg;
    logic [5:0][NUM_W-1:0]  num_reg;
    dv_side_t               dm2_reg;
    logic [5:0][NUM_W-1:0]  num_next;

    // divider output
    logic                   dv_valid;
    logic [5:0][QUOT_W-1:0] dv_quot;
    logic [5:0]             dv_over;
    logic [DV_SIDE_W-1:0]   dv_side_raw;
    dv_side_t               dv_side;

    // output register
    logic [5:0][DATA_W-1:0] acc_next;
    logic [5:0]             sat_lane;
    logic [1:0]             status_next;
    logic                   m_valid_reg;
    logic [5:0][DATA_W-1:0] acc_reg;
    logic [1:0]             m_status_reg;

    sgpa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // hold every stage while the result register is full and not taken
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    assign pos_a = {s_first_z, s_first_y, s_first_x};
    assign pos_b = {s_second_z, s_second_y, s_second_x};

    always_comb begin
        logic [DATA_W:0] da;
        logic [DATA_W:0] db;
        logic [DATA_W:0] d;
        for (int k = 0; k < 3; k++) begin
            da = {{EXT_W{pos_a[k][POS_W-1]}}, pos_a[k][POS_W-1:0]};
            db = {{EXT_W{pos_b[k][POS_W-1]}}, pos_b[k][POS_W-1:0]};
            d  = db - da;
            neg_next[k] = d[DATA_W];
            mag_next[k] = d[DATA_W] ? MAG_W'(-d) : d[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vm1_reg <= sq_valid;
            vm2_reg <= vm1_reg;
        end
    end

    // stages 1 to 3: differences, squares and G*mass, sum of squares
    always_ff @(posedge aclk) begin
        if (adv) begin
            mag1_reg  <= mag_next;
            neg1_reg  <= neg_next;
            ma1_reg   <= s_first_mass;
            mb1_reg   <= s_second_mass;

            for (int k = 0; k < 3; k++) begin
                sq2_reg[k] <= mag1_reg[k] * mag1_reg[k];
            end
            ssq2_reg  <= cfg.softening * cfg.softening;
            ga2_reg   <= cfg.gravity_const * mb1_reg;
            gb2_reg   <= cfg.gravity_const * ma1_reg;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            zero2_reg <= (mag1_reg == '0);

            r2_reg    <= R2_W'(sq2_reg[0]) + R2_W'(sq2_reg[1])
                       + R2_W'(sq2_reg[2]) + R2_W'(ssq2_reg);
            ga3_reg   <= ga2_reg;
            gb3_reg   <= gb2_reg;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    always_comb begin
        sq_in_side.ga   = ga3_reg;
        sq_in_side.gb   = gb3_reg;
        sq_in_side.mag  = mag3_reg;
        sq_in_side.neg  = neg3_reg;
        sq_in_side.zero = zero3_reg;
        sq_in_side.r2   = r2_reg;
    end

    sgpa_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v3_reg),
        .in_rad    ({r2_reg, {FRAC_PAD{1'b0}}}),
        .in_side   (sq_in_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_raw)
    );

    assign sq_side = sq_side_t'(sq_side_raw);

    // lanes 0..2 use G*m_b for particle a, lanes 3..5 use G*m_a for particle b
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lane_mag[k]   = sq_side.mag[k];
            lane_mag[k+3] = sq_side.mag[k];
            lane_glo[k]   = sq_side.ga[DATA_W-1:0];
            lane_ghi[k]   = sq_side.ga[GM_W-1:DATA_W];
            lane_glo[k+3] = sq_side.gb[DATA_W-1:0];
            lane_ghi[k+3] = sq_side.gb[GM_W-1:DATA_W];
            dm1_next.neg_a[k] = sq_side.neg[k];
            dm1_next.neg_b[k] = !sq_side.neg[k] && (sq_side.mag[k] != '0);
        end
        dm1_next.zero = sq_side.zero;
    end

    // r^3 ~ R2 * root and the numerators, as partial products
    always_ff @(posedge aclk) begin
        if (adv) begin
            pll_reg <= sq_side.r2[32:0]  * sq_root[24:0];
            plh_reg <= sq_side.r2[32:0]  * sq_root[ROOT_W-1:25];
            phl_reg <= sq_side.r2[R2_W-1:33] * sq_root[24:0];
            phh_reg <= sq_side.r2[R2_W-1:33] * sq_root[ROOT_W-1:25];
            for (int l = 0; l < 6; l++) begin
                nlo_reg[l] <= lane_glo[l] * lane_mag[l];
                nhi_reg[l] <= lane_ghi[l] * lane_mag[l];
            end
            dm1_reg <= dm1_next;
        end
    end

    always_comb begin
        logic [GM_W+MAG_W-1:0] prod;
        for (int l = 0; l < 6; l++) begin
            prod        = (GM_W+MAG_W)'(nlo_reg[l]) + ((GM_W+MAG_W)'(nhi_reg[l]) << DATA_W);
            num_next[l] = {prod, {NUM_SHIFT{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg   <= P_W'(pll_reg) + (P_W'(plh_reg) << 25)
                     + (P_W'(phl_reg) << 33) + (P_W'(phh_reg) << 58);
            num_reg <= num_next;
            dm2_reg <= dm1_reg;
        end
    end

    sgpa_div #(
        .LANES  (DIV_LANES),
        .N_W    (NUM_W),
        .D_W    (P_W),
        .Q_W    (QUOT_W),
        .SIDE_W (DV_SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vm2_reg),
        .in_num    (num_reg),
        .in_den    (p_reg),
        .in_side   (dm2_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_over  (dv_over),
        .out_side  (dv_side_raw)
    );

    assign dv_side = dv_side_t'(dv_side_raw);

    always_comb begin
        logic [QUOT_W:0] e;
        for (int l = 0; l < 6; l++) begin
            e = encode(dv_quot[l], dv_over[l],
                       (l < 3) ? dv_side.neg_a[l % 3] : dv_side.neg_b[l % 3]);
            sat_lane[l] = e[QUOT_W];
            acc_next[l] = dv_side.zero ? '0 : e[QUOT_W-1:0];
        end
        priority if (dv_side.zero) begin
            status_next = ST_ZERO;
        end else if (sat_lane != '0) begin
            status_next = ST_SAT;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg      <= acc_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accel_first_x  = acc_reg[0];
    assign m_accel_first_y  = acc_reg[1];
    assign m_accel_first_z  = acc_reg[2];
    assign m_accel_second_x = acc_reg[3];
    assign m_accel_second_y = acc_reg[4];
    assign m_accel_second_z = acc_reg[5];
    assign m_status         = m_status_reg;

    `SGPA_ASSERT_IMP(a_zero_outputs, m_valid_reg && (m_status_reg == ST_ZERO), acc_reg == '0, "zero distance result carries a nonzero acceleration")
    `SGPA_ASSERT_IMP(a_sat_at_limit, m_valid_reg && (m_status_reg == ST_SAT), (acc_reg[0] == LIMIT_POS) || (acc_reg[0] == LIMIT_NEG) || (acc_reg[1] == LIMIT_POS) || (acc_reg[1] == LIMIT_NEG) || (acc_reg[2] == LIMIT_POS) || (acc_reg[2] == LIMIT_NEG) || (acc_reg[3] == LIMIT_POS) || (acc_reg[3] == LIMIT_NEG) || (acc_reg[4] == LIMIT_POS) || (acc_reg[4] == LIMIT_NEG) || (acc_reg[5] == LIMIT_POS) || (acc_reg[5] == LIMIT_NEG), "saturation flagged but no component at a limit")
    `SGPA_ASSERT_NXT(a_stall_holds, !adv, $stable(v3_reg) && $stable(r2_reg) && $stable(vm2_reg) && $stable(p_reg), "pipeline moved during a stall")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// Softened gravity pair accelerator testbench
// Streams particle pairs through the valid/ready channels under random
// idling on both sides. A bit-exact fixed-point model of the softened
// pair force predicts each untyped pair's result; results are compared
// field by field in order. Configuration is rewritten over APB between
// phases, extremes included.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import sgpa_pkg::*;

    localparam int LATENCY_WAIT = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 14;
    localparam logic [APB_ADDR_W-1:0] ADDR_GRAVITY = APB_ADDR_W'(4 * REG_GRAVITY);
    localparam logic [APB_ADDR_W-1:0] ADDR_SOFTEN  = APB_ADDR_W'(4 * REG_SOFTEN);

    typedef struct packed {
        logic [2:0][31:0] first;    // [0] = x
        logic [2:0][31:0] second;
        logic [31:0]      first_mass;
        logic [31:0]      second_mass;
    } pair_t;

    typedef struct packed {
        logic [5:0][31:0] acc;      // first x,y,z then second x,y,z
        logic [1:0]       status;
    } accel_t;

    typedef struct packed {
        pair_t  pr;
        logic   typed;
        accel_t want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    pair_t s_pair = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    accel_t m_res;

    // payload side tags, travel with the transfer
    logic   cur_typed = 1'b0;
    accel_t cur_want = '0;

    logic [31:0] gravity_q = GRAVITY_RESET;
    logic [31:0] soften_q  = SOFTEN_RESET;
    accel_t      expected_accels[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    softened_gravity_pair_accel dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_first_x(s_pair.first[0]), .s_first_y(s_pair.first[1]),
        .s_first_z(s_pair.first[2]),
        .s_second_x(s_pair.second[0]), .s_second_y(s_pair.second[1]),
        .s_second_z(s_pair.second[2]),
        .s_first_mass(s_pair.first_mass), .s_second_mass(s_pair.second_mass),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_accel_first_x(m_res.acc[0]), .m_accel_first_y(m_res.acc[1]),
        .m_accel_first_z(m_res.acc[2]),
        .m_accel_second_x(m_res.acc[3]), .m_accel_second_y(m_res.acc[4]),
        .m_accel_second_z(m_res.acc[5]),
        .m_status(m_res.status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // {saturated, Q16.16 code} from a magnitude and a sign
    function automatic logic [32:0] sat_code(logic [127:0] mag, bit neg);
        logic [127:0] lim;
        logic [31:0]  m;
        bit           sat;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        sat = mag > lim;
        m   = sat ? lim[31:0] : mag[31:0];
        return {sat, neg ? -m : m};
    endfunction

    function automatic accel_t pair_accel(pair_t pr);
        logic [32:0]  dk;
        logic [32:0]  mg [3];
        bit           ng [3];
        bit           any, sat;
        logic [127:0] r2, rad, p, ga, gb, qa, qb;
        logic [63:0]  root, c;
        logic [32:0]  ca, cb;
        accel_t       res;
        any = 1'b0;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            dk = {pr.second[k][31], pr.second[k]} - {pr.first[k][31], pr.first[k]};
            ng[k] = dk[32];
            mg[k] = ng[k] ? -dk : dk;
            if (mg[k] != 0) any = 1'b1;
        end
        res = '0;
        if (!any) begin
            res.status = ST_ZERO;
            return res;
        end
        r2 = 128'(soften_q) * 128'(soften_q);
        for (int k = 0; k < 3; k++) r2 += 128'(mg[k]) * 128'(mg[k]);
        rad  = r2 << 32;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            c = root | (64'd1 << b);
            if (128'(c) * 128'(c) <= rad) root = c;
        end
        p  = r2 * 128'(root);
        ga = 128'(gravity_q) * 128'(pr.second_mass);
        gb = 128'(gravity_q) * 128'(pr.first_mass);
        for (int k = 0; k < 3; k++) begin
            qa = ((ga * 128'(mg[k])) << 24) / p;
            qb = ((gb * 128'(mg[k])) << 24) / p;
            ca = sat_code(qa, ng[k]);
            cb = sat_code(qb, !ng[k] && mg[k] != 0);
            res.acc[k]     = ca[31:0];
            res.acc[3 + k] = cb[31:0];
            sat = sat | ca[32] | cb[32];
        end
        res.status = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    // record expectations on input transfers, check on output transfers
    always @(posedge aclk) begin
        accel_t want;
        accel_t fresh;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("softened_gravity_pair_accel test failed");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            fresh = cur_typed ? cur_want : pair_accel(s_pair);
            expected_accels = {expected_accels, fresh};
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_accels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_res);
            end else begin
                want = expected_accels.pop_front();
                for (int f = 0; f < 7; f++) begin
                    if (f < 6 ? (m_res.acc[f] !== want.acc[f])
                              : (m_res.status !== want.status)) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d mismatch: expected %h got %h (%h)",
                                     f, f < 6 ? want.acc[f] : 32'(want.status),
                                     f < 6 ? m_res.acc[f] : 32'(m_res.status), m_res);
                    end
                end
            end
        end
    end

    always @(posedge aclk)
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 12);

    task automatic send_pair(pair_t pr, logic typed, accel_t want);
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pair    <= pr;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // drain the pipeline, then load both registers
    task automatic set_config(logic [31:0] g, logic [31:0] s);
        s_valid <= 1'b0;
        while (expected_accels.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
        reg_write(ADDR_GRAVITY, g);
        reg_write(ADDR_SOFTEN, s);
        gravity_q = g;
        soften_q  = s;
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t pr;
        int    kind;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            pr.first[k] = $urandom;
            if (kind < 10)
                pr.second[k] = pr.first[k];
            else if (kind < 60)
                pr.second[k] = pr.first[k] + ($urandom_range(0, 1 << 22) - (1 << 21));
            else if (kind < 85)
                pr.second[k] = $urandom;
            else begin
                pr.first[k]  = pick_extreme();
                pr.second[k] = pick_extreme();
            end
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                pr.first_mass  = $urandom_range(0, 1 << 20);
                pr.second_mass = $urandom_range(0, 1 << 20);
            end
            5, 6, 7: begin
                pr.first_mass  = $urandom;
                pr.second_mass = $urandom;
            end
            default: begin
                pr.first_mass  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0001_0000;
                pr.second_mass = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            end
        endcase
        return pr;
    endfunction

    localparam accel_t ZERO_DIST = '{acc: '0, status: ST_ZERO};
    localparam accel_t ALL_ZERO  = '{acc: '0, status: ST_OK};

    row_t dir_rows [N_DIRECTED] = '{
        '{'{'{32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0},
            32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, ZERO_DIST},
        '{'{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
            32'h0001_0000, 32'h0001_0000}, 1'b1, ZERO_DIST},
        '{'{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
            32'd0, 32'hFFFF_FFFF}, 1'b1, ZERO_DIST},
        '{'{'{32'd0, 32'd0, 32'd0}, '{32'h0001_0000, 32'hFFFF_0000, 32'd5},
            32'd0, 32'd0}, 1'b1, ALL_ZERO},
        '{'{'{32'd0, 32'd0, 32'd0}, '{32'h0001_0000, 32'd0, 32'd0},
            32'h0001_0000, 32'h0001_0000}, 1'b0, ALL_ZERO},
        '{'{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
            32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
        '{'{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
            32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
        '{'{'{32'd100, 32'd0, 32'd0}, '{32'd101, 32'd0, 32'd0},
            32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
        '{'{'{32'd0, 32'h0002_0000, 32'd0}, '{32'd0, 32'hFFFE_0000, 32'd0},
            32'h0003_0000, 32'h0000_8000}, 1'b0, ALL_ZERO},
        '{'{'{32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'hFFFF_FFFF},
            32'h0001_0000, 32'h0100_0000}, 1'b0, ALL_ZERO},
        '{'{'{32'd0, 32'h7FFF_FFFF, 32'd0}, '{32'd0, 32'h8000_0000, 32'd0},
            32'hFFFF_FFFF, 32'd1}, 1'b0, ALL_ZERO},
        '{'{'{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}, '{32'd1, 32'hFFFF_FFFF, 32'd1},
            32'hFFFF_FFFF, 32'd1}, 1'b0, ALL_ZERO},
        '{'{'{32'h0010_0000, 32'hFFF0_0000, 32'h0000_1234},
            '{32'hFFF0_0000, 32'h0010_0000, 32'hAAAA_5555},
            32'h5555_AAAA, 32'hAAAA_5555}, 1'b0, ALL_ZERO},
        '{'{'{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F},
            '{32'h1234_5679, 32'h9ABC_DEF0, 32'h0F0F_0F0F},
            32'h0001_0000, 32'h0001_0000}, 1'b0, ALL_ZERO}
    };

    initial begin
        logic [31:0] phase_g [5];
        logic [31:0] phase_s [5];
        int          idx;
        phase_g = '{32'hFFFF_FFFF, 32'd0, 32'h0100_0000, $urandom, GRAVITY_RESET};
        phase_s = '{32'd0, 32'hFFFF_FFFF, $urandom_range(0, 1 << 20), $urandom,
                    SOFTEN_RESET};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_pair(dir_rows[i].pr, dir_rows[i].typed, dir_rows[i].want);

        idx = 0;
        for (int ph = 0; ph < 5; ph++) begin
            set_config(phase_g[ph], phase_s[ph]);
            // zero distance must hold whatever the registers say
            send_pair(dir_rows[0].pr, 1'b1, ZERO_DIST);
            for (int n = 0; n < 90; n++) begin
                calm = idx >= 180 && idx < 300;
                send_pair(random_pair(), 1'b0, ALL_ZERO);
                idx++;
            end
            calm = 1'b0;
        end
        s_valid <= 1'b0;

        while (expected_accels.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
        if (mismatches == 0 && expected_accels.size() == 0)
            $display("softened_gravity_pair_accel test passed");
        else
            $display("softened_gravity_pair_accel test failed");
        $finish;
    end

endmodule

`default_nettype wire
